### design/aps_pkg.sv
// Shared types, constants and helper functions for the acquisition priority scheduler.
// No dependencies; every other design file imports this package.
package aps_pkg;

  localparam int NUM_SATS = 32;
  localparam int PRIO_W   = 16;
  localparam int IDX_W    = $clog2(NUM_SATS);
  localparam int CNT_W    = $clog2(NUM_SATS + 1);
  localparam int SAT_W    = 6;
  localparam int MASK_W   = 32;
  localparam int DATA_W   = 32;

  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam logic [DATA_W-1:0] SNIFF_RESET = 32'd70000;

  localparam prio_t PRIO_RESET   = prio_t'(32);
  localparam prio_t BUMP_STRONG  = prio_t'(16);
  localparam prio_t BUMP_WEAK    = prio_t'(8);
  localparam prio_t BUMP_NONE    = prio_t'(0);
  localparam prio_t AGE_HIGH_ERR = prio_t'(4);
  localparam prio_t AGE_NORMAL   = prio_t'(1);
  localparam prio_t LAUNCH_DROP  = prio_t'(32);
  localparam prio_t BOOST_STEP   = prio_t'(32);

  localparam logic [1:0] MODE_FINISH = 2'd0;
  localparam logic [1:0] MODE_LAUNCH = 2'd1;
  localparam logic [1:0] MODE_BOOST  = 2'd2;
  localparam logic [1:0] MODE_POWER  = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SAT_W-1:0]  sv_id;
    logic [DATA_W-1:0] power;
    logic [MASK_W-1:0] tracking_mask;
    logic [MASK_W-1:0] acquiring_mask;
    logic [MASK_W-1:0] low_error_mask;
    logic [MASK_W-1:0] high_error_mask;
    logic              channel_exists;
    logic [DATA_W-1:0] channel_power;
    logic [DATA_W-1:0] freq_step;
    logic [DATA_W-1:0] code_offset;
  } item_t;

  typedef struct packed {
    logic              launch_valid;
    logic [SAT_W-1:0]  launch_sv;
    logic              none_eligible;
    logic              add_channel;
    logic              clear_bit_errors;
    logic [DATA_W-1:0] add_freq_step;
    logic [DATA_W-1:0] add_code_offset;
  } result_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic proc;
    logic drop_wr;
    logic boost_rd;
    logic boost_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       sv_ok;
  } status_t;

  function automatic prio_t sat_add(prio_t p, prio_t amt);
    logic [PRIO_W:0] sum;
    sum = {1'b0, p} + {1'b0, amt};
    return sum[PRIO_W] ? '1 : sum[PRIO_W-1:0];
  endfunction

  function automatic logic mask_bit(logic [MASK_W-1:0] m, idx_t i);
    logic b;
    b = 1'b0;
    if (32'(i) < MASK_W) b = m[5'(i)];
    return b;
  endfunction

  function automatic idx_t next_idx(idx_t i);
    return (32'(i) == NUM_SATS - 1) ? '0 : idx_t'(32'(i) + 1);
  endfunction

endpackage

### design/aps_intf.sv
// Handshake channel interfaces: input items, results and configuration writes.
// Depends on aps_pkg for field widths.
interface aps_item_if import aps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [SAT_W-1:0]  sv_id;
  logic [DATA_W-1:0] power;
  logic [MASK_W-1:0] tracking_mask;
  logic [MASK_W-1:0] acquiring_mask;
  logic [MASK_W-1:0] low_error_mask;
  logic [MASK_W-1:0] high_error_mask;
  logic              channel_exists;
  logic [DATA_W-1:0] channel_power;
  logic [DATA_W-1:0] freq_step;
  logic [DATA_W-1:0] code_offset;
  modport source (output valid, mode, sv_id, power, tracking_mask, acquiring_mask,
                  low_error_mask, high_error_mask, channel_exists, channel_power,
                  freq_step, code_offset, input ready);
  modport sink (input valid, mode, sv_id, power, tracking_mask, acquiring_mask,
                low_error_mask, high_error_mask, channel_exists, channel_power,
                freq_step, code_offset, output ready);
endinterface

interface aps_result_if import aps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              launch_valid;
  logic [SAT_W-1:0]  launch_sv;
  logic              none_eligible;
  logic              add_channel;
  logic              clear_bit_errors;
  logic [DATA_W-1:0] add_freq_step;
  logic [DATA_W-1:0] add_code_offset;
  modport source (output valid, launch_valid, launch_sv, none_eligible, add_channel,
                  clear_bit_errors, add_freq_step, add_code_offset, input ready);
  modport sink (input valid, launch_valid, launch_sv, none_eligible, add_channel,
                clear_bit_errors, add_freq_step, add_code_offset, output ready);
endinterface

interface aps_cfg_if import aps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/aps_dpath.sv
// Datapath: priority memory with valid bits, aging/scan pipeline, power decision,
// power_limit register and result register. Depends on aps_pkg; driven by aps_ctrl.
module aps_dpath import aps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  item_t             item,
  input  logic              cfg_write,
  input  logic [DATA_W-1:0] cfg_data,
  output result_t           result
);

  prio_t             mem [NUM_SATS];
  logic [NUM_SATS-1:0] vld;

  item_t             item_q;
  logic              sv_ok;
  idx_t              start_idx;
  idx_t              rd_addr;
  idx_t              proc_addr;
  prio_t             rd_data_q;
  logic              rd_vld_q;
  idx_t              best;
  prio_t             best_p;
  logic              found;
  logic [DATA_W-1:0] power_limit;

  logic    sv_in_ok;
  idx_t    sv_in_idx;
  idx_t    ra;
  prio_t   rd_data;
  prio_t   bump_amt;
  prio_t   bumped;
  prio_t   new_p;
  prio_t   drop_p;
  logic    elig;
  logic    wr_en;
  idx_t    wr_addr;
  prio_t   wr_data;
  logic    pwr_add;
  result_t result_next;

  assign sv_in_ok  = (item.sv_id != '0) && (32'(item.sv_id) <= NUM_SATS);
  assign sv_in_idx = sv_in_ok ? idx_t'(32'(item.sv_id) - 1) : idx_t'(NUM_SATS - 1);

  assign status.mode  = item_q.mode;
  assign status.sv_ok = sv_ok;

  assign rd_data = rd_vld_q ? rd_data_q : PRIO_RESET;
  assign ra      = cmd.boost_rd ? start_idx : rd_addr;

  always_comb begin
    if (item_q.power > power_limit) begin
      bump_amt = BUMP_STRONG;
    end else if (item_q.power > (power_limit >> 1)) begin
      bump_amt = BUMP_WEAK;
    end else begin
      bump_amt = BUMP_NONE;
    end
    bumped = (sv_ok && proc_addr == start_idx) ? sat_add(rd_data, bump_amt) : rd_data;
    if (item_q.mode != MODE_FINISH) begin
      new_p = rd_data;
    end else if (mask_bit(item_q.tracking_mask, proc_addr) &&
                 mask_bit(item_q.low_error_mask, proc_addr)) begin
      new_p = '0;
    end else if (mask_bit(item_q.high_error_mask, proc_addr)) begin
      new_p = sat_add(bumped, AGE_HIGH_ERR);
    end else begin
      new_p = sat_add(bumped, AGE_NORMAL);
    end
  end

  assign elig   = !mask_bit(item_q.tracking_mask, proc_addr) &&
                  !mask_bit(item_q.acquiring_mask, proc_addr);
  assign drop_p = (best_p > LAUNCH_DROP) ? prio_t'(best_p - LAUNCH_DROP) : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_addr;
    wr_data = new_p;
    if (cmd.proc) begin
      wr_en = 1'b1;
    end else if (cmd.drop_wr) begin
      wr_en   = 1'b1;
      wr_addr = best;
      wr_data = drop_p;
    end else if (cmd.boost_wr) begin
      wr_en   = 1'b1;
      wr_addr = start_idx;
      wr_data = sat_add(rd_data, BOOST_STEP);
    end
  end

  assign pwr_add = (item_q.power > power_limit) &&
                   (!item_q.channel_exists ||
                    ({1'b0, item_q.power} > {item_q.channel_power, 1'b0}));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en || cmd.boost_rd) rd_data_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en || cmd.boost_rd) rd_vld_q <= vld[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_limit <= SNIFF_RESET;
    end else if (cfg_write) begin
      power_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_q    <= item;
      sv_ok     <= sv_in_ok;
      start_idx <= sv_in_idx;
      rd_addr   <= next_idx(sv_in_idx);
      best      <= sv_in_idx;
      best_p    <= '0;
      found     <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_addr   <= next_idx(rd_addr);
        proc_addr <= rd_addr;
      end
      // scan order runs from after the start entry and ends on it; ties go to the later one
      if (cmd.proc) begin
        if (elig && (!found || new_p >= best_p)) begin
          found  <= 1'b1;
          best_p <= new_p;
          best   <= proc_addr;
        end else if (!found) begin
          best_p <= new_p;
        end
      end
    end
  end

  always_comb begin
    result_next = '0;
    if (item_q.mode == MODE_FINISH || item_q.mode == MODE_LAUNCH) begin
      result_next.launch_valid  = 1'b1;
      result_next.launch_sv     = SAT_W'(32'(best) + 1);
      result_next.none_eligible = !found;
    end else if (item_q.mode == MODE_POWER && pwr_add) begin
      result_next.add_channel      = 1'b1;
      result_next.clear_bit_errors = item_q.channel_exists;
      result_next.add_freq_step    = item_q.freq_step;
      result_next.add_code_offset  = item_q.code_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) result <= result_next;
  end

  a_rw_distinct: assert property (@(posedge clk) disable iff (rst)
    (cmd.proc && cmd.rd_en) |-> (proc_addr != rd_addr))
    else $error("sweep read and write hit the same entry");

  a_drop_below: assert property (@(posedge clk) disable iff (rst)
    cmd.drop_wr |-> (wr_data <= best_p))
    else $error("launch drop raised a priority");

  a_scan_init: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (!found && best == start_idx))
    else $error("scan state not initialized on transfer");

endmodule

### design/aps_ctrl.sv
// Controller state machine: input/result handshakes and command sequencing for aps_dpath.
// Depends on aps_pkg.
module aps_ctrl import aps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DROP  = 3'd3;
  localparam logic [2:0] S_BRD   = 3'd4;
  localparam logic [2:0] S_BWR   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cnt_next = '0;
        case (status.mode)
          MODE_FINISH, MODE_LAUNCH: state_next = S_SWEEP;
          MODE_BOOST:               state_next = status.sv_ok ? S_BRD : S_FIN;
          default:                  state_next = S_FIN;
        endcase
      end
      S_SWEEP: begin
        cmd.rd_en = (32'(cnt) < NUM_SATS);
        cmd.proc  = (cnt != '0);
        cnt_next  = CNT_W'(32'(cnt) + 1);
        if (32'(cnt) == NUM_SATS) state_next = S_DROP;
      end
      S_DROP: begin
        cmd.drop_wr = 1'b1;
        state_next  = S_FIN;
      end
      S_BRD: begin
        cmd.boost_rd = 1'b1;
        state_next   = S_BWR;
      end
      S_BWR: begin
        cmd.boost_wr = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not offered");

  a_sweep_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && 32'(cnt) == NUM_SATS) |=> (state == S_DROP))
    else $error("sweep did not end after all entries");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("finished result overwrote a pending one");

endmodule

### design/acquisition_priority_scheduler.sv
// Acquisition priority scheduler top level: one item at a time, one result per item.
// Finish and launch modes sweep all entries before the result is loaded; a boost reads
// and writes back its own entry; a power report or an out-of-range boost has no sweep.
// The next item is taken only after the result is registered; the sweep reads one entry
// and writes one a cycle.
// Synchronous reset: power limit = 70000, every priority reads 32 (valid bits cleared).
module acquisition_priority_scheduler import aps_pkg::*; (
  input logic         clk,
  input logic         rst,
  aps_item_if.sink    item,
  aps_result_if.source result,
  aps_cfg_if.sink     cfg
);

  cmd_t    cmd;
  status_t status;
  item_t   item_s;
  result_t res_s;

  assign item_s.mode            = item.mode;
  assign item_s.sv_id           = item.sv_id;
  assign item_s.power           = item.power;
  assign item_s.tracking_mask   = item.tracking_mask;
  assign item_s.acquiring_mask  = item.acquiring_mask;
  assign item_s.low_error_mask  = item.low_error_mask;
  assign item_s.high_error_mask = item.high_error_mask;
  assign item_s.channel_exists  = item.channel_exists;
  assign item_s.channel_power   = item.channel_power;
  assign item_s.freq_step       = item.freq_step;
  assign item_s.code_offset     = item.code_offset;

  assign cfg.ready = !rst;

  aps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  aps_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item_s),
    .cfg_write (cfg.valid),
    .cfg_data  (cfg.data),
    .result    (res_s)
  );

  assign result.launch_valid     = res_s.launch_valid;
  assign result.launch_sv        = res_s.launch_sv;
  assign result.none_eligible    = res_s.none_eligible;
  assign result.add_channel      = res_s.add_channel;
  assign result.clear_bit_errors = res_s.clear_bit_errors;
  assign result.add_freq_step    = res_s.add_freq_step;
  assign result.add_code_offset  = res_s.add_code_offset;

endmodule

### verif/acquisition_priority_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for acquisition_priority_scheduler: directed and random items
// checked against a priority-table scoreboard. Needs aps_pkg and the aps_*_if interfaces.
module acquisition_priority_scheduler_tb;
  import aps_pkg::*;

  localparam int PRIO_MAX       = (1 << PRIO_W) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_TAIL     = NUM_SATS + 8;

  logic clk = 1'b0;
  logic rst;

  aps_item_if   item_ch ();
  aps_result_if res_ch ();
  aps_cfg_if    cfg_ch ();

  acquisition_priority_scheduler u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  prio_t             prio_shadow [NUM_SATS];
  logic [DATA_W-1:0] shadow_limit;
  result_t           pending_results [$];
  int                mismatches   = 0;
  int                burst_left   = 0;
  bit                gaps_off     = 1'b0;
  bit                item_held    = 1'b0;
  int                quiet_cycles = 0;
  logic [31:0]       stall_count  = '0;
  int                stall_style  = 0;
  int                hold_left    = 0;

  function automatic void prio_raise(int sat, int amount);
    int sum;
    sum = int'(prio_shadow[sat-1]) + amount;
    prio_shadow[sat-1] = (sum > PRIO_MAX) ? prio_t'(PRIO_MAX) : prio_t'(sum);
  endfunction

  function automatic result_t predict_schedule(item_t it);
    result_t r;
    int      start;
    int      cur;
    int      pick;
    logic    found;
    logic    in_range;
    prio_t   top;
    r = '0;
    in_range = (it.sv_id >= 1) && (it.sv_id <= NUM_SATS);
    if (it.mode == MODE_FINISH) begin
      if (in_range) begin
        if (it.power > shadow_limit) prio_raise(int'(it.sv_id), int'(BUMP_STRONG));
        else if (it.power > (shadow_limit >> 1)) prio_raise(int'(it.sv_id), int'(BUMP_WEAK));
      end
      for (int s = 1; s <= NUM_SATS; s++) begin
        if (it.tracking_mask[s-1] && it.low_error_mask[s-1]) prio_shadow[s-1] = '0;
        else if (it.high_error_mask[s-1]) prio_raise(s, int'(AGE_HIGH_ERR));
        else prio_raise(s, int'(AGE_NORMAL));
      end
    end
    case (it.mode)
      MODE_FINISH, MODE_LAUNCH: begin
        // round-robin from start+1, wrapping back to start; ties go to the later entry
        start = in_range ? int'(it.sv_id) : NUM_SATS;
        cur   = start;
        pick  = start;
        found = 1'b0;
        top   = '0;
        for (int n = 0; n < NUM_SATS; n++) begin
          cur = (cur == NUM_SATS) ? 1 : cur + 1;
          if (!it.tracking_mask[cur-1] && !it.acquiring_mask[cur-1] &&
              (!found || prio_shadow[cur-1] >= top)) begin
            found = 1'b1;
            top   = prio_shadow[cur-1];
            pick  = cur;
          end
        end
        prio_shadow[pick-1] = (prio_shadow[pick-1] > LAUNCH_DROP) ?
                              prio_shadow[pick-1] - LAUNCH_DROP : '0;
        r.launch_valid  = 1'b1;
        r.launch_sv     = SAT_W'(pick);
        r.none_eligible = !found;
      end
      MODE_BOOST: begin
        if (in_range) prio_raise(int'(it.sv_id), int'(BOOST_STEP));
      end
      default: begin
        if (it.power > shadow_limit &&
            (!it.channel_exists || {1'b0, it.power} > {it.channel_power, 1'b0})) begin
          r.add_channel      = 1'b1;
          r.clear_bit_errors = it.channel_exists;
          r.add_freq_step    = it.freq_step;
          r.add_code_offset  = it.code_offset;
        end
      end
    endcase
    return r;
  endfunction

  function automatic item_t quiet_item(logic [1:0] mode, logic [SAT_W-1:0] sv);
    item_t it;
    it       = '0;
    it.mode  = mode;
    it.sv_id = sv;
    return it;
  endfunction

  task automatic release_item();
    if (item_held) begin
      item_ch.valid <= 1'b0;
      item_held = 1'b0;
    end
  endtask

  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gaps_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        release_item();
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid <= 1'b1;
    {item_ch.mode, item_ch.sv_id, item_ch.power, item_ch.tracking_mask,
     item_ch.acquiring_mask, item_ch.low_error_mask, item_ch.high_error_mask,
     item_ch.channel_exists, item_ch.channel_power, item_ch.freq_step,
     item_ch.code_offset} <= it;
    item_held = 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    pending_results.push_back(predict_schedule(it));
  endtask

  task automatic drain_results();
    release_item();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_power_limit(logic [DATA_W-1:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    shadow_limit = value;
  endtask

  // reset values: every priority 32, limit 70000
  task automatic test_launch_scan();
    item_t it;
    it = quiet_item(MODE_LAUNCH, 6'd32);
    send_item(it);
    it.sv_id = 6'd5;
    send_item(it);
    it.sv_id = 6'd0;
    send_item(it);
    it.sv_id          = 6'd63;
    it.tracking_mask  = 32'h5555_5555;
    it.acquiring_mask = 32'h0000_FF00;
    send_item(it);
    it = quiet_item(MODE_LAUNCH, 6'd10);
    it.tracking_mask = '1;
    send_item(it);
    it = quiet_item(MODE_LAUNCH, 6'd33);
    it.acquiring_mask = '1;
    send_item(it);
  endtask

  task automatic test_finish_aging();
    item_t it;
    it = quiet_item(MODE_FINISH, 6'd3);
    it.power           = '1;
    it.tracking_mask   = 32'h0000_00F0;
    it.low_error_mask  = 32'h0000_0030;
    it.high_error_mask = 32'h0000_0C22;
    send_item(it);
    it = quiet_item(MODE_FINISH, 6'd4);
    it.power = 32'd70000;
    send_item(it);
    it = quiet_item(MODE_FINISH, 6'd6);
    it.power = 32'd35000;
    send_item(it);
    it.sv_id           = 6'd7;
    it.power           = 32'd35001;
    it.high_error_mask = '1;
    send_item(it);
    it = quiet_item(MODE_FINISH, 6'd0);
    it.power = '1;
    send_item(it);
    it.sv_id = 6'd33;
    send_item(it);
    it.sv_id          = 6'd63;
    it.tracking_mask  = '1;
    it.low_error_mask = '1;
    send_item(it);
  endtask

  task automatic test_boost_range();
    item_t it;
    it = quiet_item(MODE_BOOST, 6'd1);
    send_item(it);
    it.sv_id = 6'd32;
    send_item(it);
    it.sv_id = 6'd0;
    send_item(it);
    it.sv_id = 6'd63;
    send_item(it);
  endtask

  task automatic test_power_report();
    item_t it;
    it = quiet_item(MODE_POWER, 6'd2);
    it.power       = 32'd70001;
    it.freq_step   = $urandom;
    it.code_offset = $urandom;
    send_item(it);
    it.power = 32'd70000;
    send_item(it);
    it.power          = 32'd70001;
    it.channel_exists = 1'b1;
    it.channel_power  = 32'd35000;
    send_item(it);
    it.channel_power = 32'd35001;
    send_item(it);
    // doubled channel power reaches 2^32 and must not wrap
    it.power         = '1;
    it.channel_power = 32'h8000_0000;
    send_item(it);
    it.channel_power = 32'h7FFF_FFFF;
    send_item(it);
    it.sv_id          = 6'd0;
    it.channel_exists = 1'b0;
    it.channel_power  = $urandom;
    it.freq_step      = ~it.freq_step;
    it.code_offset    = ~it.code_offset;
    send_item(it);
  endtask

  task automatic test_limit_extremes();
    item_t it;
    write_power_limit('0);
    it = quiet_item(MODE_POWER, 6'd12);
    it.power     = 32'd1;
    it.freq_step = $urandom;
    send_item(it);
    it.power = '0;
    send_item(it);
    it = quiet_item(MODE_FINISH, 6'd9);
    it.power = 32'd1;
    send_item(it);
    write_power_limit('1);
    it = quiet_item(MODE_POWER, 6'd12);
    it.power = '1;
    send_item(it);
    it = quiet_item(MODE_FINISH, 6'd9);
    it.power = 32'h8000_0000;
    send_item(it);
    write_power_limit(32'd1);
    it.power = 32'd1;
    send_item(it);
  endtask

  task automatic test_boost_climb();
    item_t it;
    int    sat;
    sat = $urandom_range(1, NUM_SATS);
    gaps_off = 1'b1;
    it = quiet_item(MODE_BOOST, SAT_W'(sat));
    repeat (60) send_item(it);
    it = quiet_item(MODE_FINISH, SAT_W'(sat));
    it.power           = '1;
    it.acquiring_mask  = 32'(1) << (sat - 1);
    it.high_error_mask = '1;
    repeat (2) send_item(it);
    it = quiet_item(MODE_LAUNCH, SAT_W'(sat));
    send_item(it);
    gaps_off = 1'b0;
  endtask

  task automatic test_random_traffic(logic [DATA_W-1:0] limit, int count);
    item_t it;
    int    pick;
    write_power_limit(limit);
    gaps_off = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      pick = $urandom_range(0, 19);
      it.mode = (pick < 8) ? MODE_FINISH : (pick < 12) ? MODE_LAUNCH :
                (pick < 15) ? MODE_BOOST : MODE_POWER;
      it.sv_id = ($urandom_range(0, 9) == 0) ? SAT_W'($urandom_range(0, 63)) :
                 SAT_W'($urandom_range(1, NUM_SATS));
      case ($urandom_range(0, 5))
        0: it.power = $urandom;
        1: it.power = shadow_limit + $urandom_range(0, 2) - 1;
        2: it.power = (shadow_limit >> 1) + $urandom_range(0, 2) - 1;
        3: it.power = $urandom_range(0, 200000);
        4: it.power = shadow_limit + $urandom_range(0, 100000);
        default: it.power = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      it.tracking_mask   = ($urandom_range(0, 24) == 0) ? '1 : $urandom & $urandom & $urandom;
      it.acquiring_mask  = ($urandom_range(0, 3) == 0) ? $urandom :
                           32'(1) << $urandom_range(0, 31);
      it.low_error_mask  = $urandom;
      it.high_error_mask = $urandom & $urandom;
      it.channel_exists  = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: it.channel_power = $urandom;
        1: it.channel_power = it.power >> 1;
        2: it.channel_power = (it.power >> 1) - 1;
        default: it.channel_power = $urandom_range(0, 100000);
      endcase
      it.freq_step   = $urandom;
      it.code_offset = $urandom;
      send_item(it);
    end
  endtask

  // result side: stall style picked anew whenever the low byte of stall_count wraps to zero
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count[7:0] == 8'd0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      2: res_ch.ready <= (stall_count[4:0] < 5'd11);
      default: begin
        if (hold_left != 0) begin
          res_ch.ready <= 1'b0;
          hold_left    <= hold_left - 1;
        end else begin
          res_ch.ready <= 1'b1;
          hold_left    <= $urandom_range(0, 40);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = {res_ch.launch_valid, res_ch.launch_sv, res_ch.none_eligible, res_ch.add_channel,
             res_ch.clear_bit_errors, res_ch.add_freq_step, res_ch.add_code_offset};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: lv=%0d sv=%0d ne=%0d add=%0d clr=%0d fs=%h co=%h",
                   got.launch_valid, got.launch_sv, got.none_eligible, got.add_channel,
                   got.clear_bit_errors, got.add_freq_step, got.add_code_offset);
      end else begin
        want = pending_results.pop_front();
        if (got.launch_valid !== want.launch_valid || got.launch_sv !== want.launch_sv ||
            got.none_eligible !== want.none_eligible || got.add_channel !== want.add_channel ||
            got.clear_bit_errors !== want.clear_bit_errors ||
            got.add_freq_step !== want.add_freq_step ||
            got.add_code_offset !== want.add_code_offset) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp lv=%0d sv=%0d ne=%0d add=%0d clr=%0d fs=%h co=%h",
                     $realtime, want.launch_valid, want.launch_sv, want.none_eligible,
                     want.add_channel, want.clear_bit_errors, want.add_freq_step,
                     want.add_code_offset);
            $display("    got lv=%0d sv=%0d ne=%0d add=%0d clr=%0d fs=%h co=%h",
                     got.launch_valid, got.launch_sv, got.none_eligible, got.add_channel,
                     got.clear_bit_errors, got.add_freq_step, got.add_code_offset);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("acquisition_priority_scheduler_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    {item_ch.mode, item_ch.sv_id, item_ch.power, item_ch.tracking_mask,
     item_ch.acquiring_mask, item_ch.low_error_mask, item_ch.high_error_mask,
     item_ch.channel_exists, item_ch.channel_power, item_ch.freq_step,
     item_ch.code_offset} = '0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    shadow_limit  = SNIFF_RESET;
    foreach (prio_shadow[i]) prio_shadow[i] = PRIO_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_launch_scan();
    test_finish_aging();
    test_boost_range();
    test_power_report();
    test_limit_extremes();
    test_boost_climb();
    test_random_traffic(32'd70000, 80);
    test_random_traffic($urandom, 80);
    test_random_traffic('0, 80);
    test_random_traffic($urandom_range(1000, 300000), 80);

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("acquisition_priority_scheduler_tb OK");
    else
      $display("acquisition_priority_scheduler_tb NOT OK");
    $finish;
  end

endmodule
